@@ sv/pcm_pkg.sv @@
// ----------------------------------------------------------------------------
// pcm_pkg
// shared widths, register map and pipeline tag type of the polynomial
// coefficient multiplier
// ----------------------------------------------------------------------------
`default_nettype none

package pcm_pkg;

   localparam int unsigned MAX_DEGREE_DEFAULT = 255;
   localparam int unsigned COEF_WIDTH_DEFAULT = 16;

   localparam int unsigned DEGREE_W   = 8;
   localparam int unsigned INDEX_W    = 9;
   localparam int unsigned PROD_W     = 40;
   localparam int unsigned WIDE_W     = 64;
   localparam int unsigned RSP_DATA_W = 56;

   localparam int unsigned CSR_ADDR_W = 3;
   localparam int unsigned CSR_DATA_W = 32;
   localparam int unsigned CSR_SEL_W  = CSR_ADDR_W - 2;

   localparam logic [CSR_SEL_W-1:0] REG_DEGREE = CSR_SEL_W'(0);

   typedef struct packed {
      logic vld;
      logic first;
      logic last;
   } mac_tag_type;

endpackage

`default_nettype wire

@@ sv/pcm_coef_store.sv @@
// ----------------------------------------------------------------------------
// pcm_coef_store
// operand memories: one write port for both, one registered read port each
// ----------------------------------------------------------------------------
`default_nettype none

module pcm_coef_store #(
   parameter int unsigned DEPTH  = 256,
   parameter int unsigned ADDR_W = 8,
   parameter int unsigned DATA_W = 16
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [DATA_W-1:0] wr_a,
   input  logic [DATA_W-1:0] wr_b,
   input  logic [ADDR_W-1:0] rd_addr_a,
   input  logic [ADDR_W-1:0] rd_addr_b,
   output logic [DATA_W-1:0] rd_a,
   output logic [DATA_W-1:0] rd_b
);

   logic [DATA_W-1:0] store_a_ff [DEPTH];
   logic [DATA_W-1:0] store_b_ff [DEPTH];
   logic [DATA_W-1:0] rd_a_ff;
   logic [DATA_W-1:0] rd_b_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_a_ff[wr_addr] <= wr_a;
         store_b_ff[wr_addr] <= wr_b;
      end
   end

   always_ff @(posedge clock) begin
      rd_a_ff <= store_a_ff[rd_addr_a];
      rd_b_ff <= store_b_ff[rd_addr_b];
   end

   assign rd_a = rd_a_ff;
   assign rd_b = rd_b_ff;

endmodule

`default_nettype wire

@@ sv/pcm_mac.sv @@
// ----------------------------------------------------------------------------
// pcm_mac
// registered multiplier followed by a 40-bit accumulator
// ----------------------------------------------------------------------------
`default_nettype none

module pcm_mac #(
   parameter int unsigned COEF_WIDTH = 16
) (
   input  logic                            clock,
   input  logic                            reset,
   input  pcm_pkg::mac_tag_type            tag,
   input  logic signed [COEF_WIDTH-1:0]    op_a,
   input  logic signed [COEF_WIDTH-1:0]    op_b,
   output logic signed [pcm_pkg::PROD_W-1:0] acc,
   output logic                            done
);

   import pcm_pkg::*;

   mac_tag_type                   tag2_ff;
   logic signed [2*COEF_WIDTH-1:0] prod_ff;
   logic signed [2*COEF_WIDTH-1:0] prod_in;
   logic signed [WIDE_W-1:0]       prod_wide;
   logic signed [PROD_W-1:0]       acc_ff;
   logic signed [PROD_W-1:0]       acc_in;
   logic                           done_ff;

   assign prod_in   = op_a * op_b;
   assign prod_wide = WIDE_W'(prod_ff);

   always_comb begin
      acc_in = acc_ff;
      if (tag2_ff.vld) begin
         if (tag2_ff.first) begin
            acc_in = prod_wide[PROD_W-1:0];
         end else begin
            acc_in = acc_ff + prod_wide[PROD_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      acc_ff  <= acc_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tag2_ff <= '0;
         done_ff <= 1'b0;
      end else begin
         tag2_ff <= tag;
         done_ff <= tag2_ff.vld && tag2_ff.last;
      end
   end

   assign acc  = acc_ff;
   assign done = done_ff;

endmodule

`default_nettype wire

@@ sv/pcm_ctrl.sv @@
// ----------------------------------------------------------------------------
// pcm_ctrl
// item sequencer: stores the operands, walks the convolution terms and
// hands the finished sum to the output register
// ----------------------------------------------------------------------------
`default_nettype none

module pcm_ctrl #(
   parameter int unsigned ADDR_W = 8
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic [pcm_pkg::DEGREE_W-1:0]    degree_n,
   input  logic                            cfg_wr,
   input  logic                            in_valid,
   output logic                            in_ready,
   input  logic                            out_free,
   input  logic                            mac_done,
   output logic                            wr_en,
   output logic [ADDR_W-1:0]               wr_addr,
   output logic [ADDR_W-1:0]               rd_addr_a,
   output logic [ADDR_W-1:0]               rd_addr_b,
   output pcm_pkg::mac_tag_type            tag,
   output logic                            load_out,
   output logic [pcm_pkg::INDEX_W-1:0]     coef_index,
   output logic                            last_coef
);

   import pcm_pkg::*;

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_RUN  = 2'd1;
   localparam logic [1:0] ST_WAIT = 2'd2;
   localparam logic [1:0] ST_HOLD = 2'd3;

   logic [1:0]          state_ff, state_in;
   logic [INDEX_W-1:0]  index_ff, index_in;
   logic [INDEX_W-1:0]  k_ff, k_in;
   logic                last_ff, last_in;
   logic [DEGREE_W-1:0] i_ff, i_in;
   logic [DEGREE_W-1:0] hi_ff, hi_in;
   logic                first_ff, first_in;
   mac_tag_type         tag_ff, tag_in;

   logic                accept;
   logic [INDEX_W-1:0]  n9;
   logic [INDEX_W-1:0]  two_n;
   logic [INDEX_W-1:0]  k_cur;
   logic [INDEX_W-1:0]  diff;
   logic                end_term;

   assign n9       = INDEX_W'(degree_n);
   assign two_n    = {degree_n, 1'b0};
   assign accept   = in_valid && (state_ff == ST_IDLE);
   assign k_cur    = (index_ff > two_n) ? '0 : index_ff;
   assign diff     = k_ff - INDEX_W'(i_ff);
   assign end_term = (i_ff == hi_ff);

   assign in_ready  = (state_ff == ST_IDLE);
   assign wr_en     = accept && (k_cur <= n9);
   assign wr_addr   = ADDR_W'(k_cur);
   assign rd_addr_a = ADDR_W'(i_ff);
   assign rd_addr_b = ADDR_W'(diff);
   assign load_out  = (state_ff == ST_HOLD) && out_free;

   always_comb begin
      state_in = state_ff;
      index_in = index_ff;
      k_in     = k_ff;
      last_in  = last_ff;
      i_in     = i_ff;
      hi_in    = hi_ff;
      first_in = first_ff;
      tag_in   = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_RUN;
               k_in     = k_cur;
               last_in  = (k_cur == two_n);
               index_in = (k_cur == two_n) ? '0 : k_cur + INDEX_W'(1);
               i_in     = (k_cur > n9) ? DEGREE_W'(k_cur - n9) : '0;
               hi_in    = (k_cur < n9) ? DEGREE_W'(k_cur) : degree_n;
               first_in = 1'b1;
            end
         end
         ST_RUN: begin
            tag_in.vld   = 1'b1;
            tag_in.first = first_ff;
            tag_in.last  = end_term;
            first_in     = 1'b0;
            if (end_term) begin
               state_in = ST_WAIT;
            end else begin
               i_in = i_ff + DEGREE_W'(1);
            end
         end
         ST_WAIT: begin
            if (mac_done) begin
               state_in = ST_HOLD;
            end
         end
         ST_HOLD: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      if (cfg_wr) begin
         index_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         index_ff <= '0;
         tag_ff   <= '0;
      end else begin
         state_ff <= state_in;
         index_ff <= index_in;
         tag_ff   <= tag_in;
      end
   end

   always_ff @(posedge clock) begin
      k_ff     <= k_in;
      last_ff  <= last_in;
      i_ff     <= i_in;
      hi_ff    <= hi_in;
      first_ff <= first_in;
   end

   assign tag        = tag_ff;
   assign coef_index = k_ff;
   assign last_coef  = last_ff;

endmodule

`default_nettype wire

@@ sv/polynomial_coefficient_multiplier_unit.sv @@
// ----------------------------------------------------------------------------
// polynomial_coefficient_multiplier_unit
// schoolbook product of two integer polynomials, one product coefficient per
// input transaction
// ----------------------------------------------------------------------------
//  channel | direction | handshake               | content
//  req     | in        | req_tvalid / req_tready | coefficient k of both operands
//  rsp     | out       | rsp_tvalid / rsp_tready | product coefficient k, index, last
//  csr     | in        | psel, penable, pready   | degree register at address 0
//
//  one transaction stores its operands, then reads, multiplies and
//  accumulates the terms lo..hi in turn before the hand-over; the single
//  shared multiplier and one read per operand memory per cycle set its
//  length
//  reset is synchronous and clears control state and the degree register
//  only; the memories need no clearing
//  a result waiting on rsp does not hold off the next req transaction until
//  the following sum is complete
// ----------------------------------------------------------------------------
`default_nettype none

module polynomial_coefficient_multiplier_unit
   import pcm_pkg::MAX_DEGREE_DEFAULT, pcm_pkg::COEF_WIDTH_DEFAULT;
#(
   parameter int unsigned MAX_DEGREE = MAX_DEGREE_DEFAULT,
   parameter int unsigned COEF_WIDTH = COEF_WIDTH_DEFAULT
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    req_tvalid,
   output logic                                    req_tready,
   // a_coef, b_coef
   input  logic [((2*COEF_WIDTH+7)/8)*8-1:0]       req_tdata,
   output logic                                    rsp_tvalid,
   input  logic                                    rsp_tready,
   // product_coef, coef_index
   output logic [pcm_pkg::RSP_DATA_W-1:0]          rsp_tdata,
   output logic                                    rsp_tlast,
   input  logic                                    csr_psel,
   input  logic                                    csr_penable,
   input  logic                                    csr_pwrite,
   input  logic [pcm_pkg::CSR_ADDR_W-1:0]          csr_paddr,
   input  logic [pcm_pkg::CSR_DATA_W-1:0]          csr_pwdata,
   output logic [pcm_pkg::CSR_DATA_W-1:0]          csr_prdata,
   output logic                                    csr_pready
);

   import pcm_pkg::*;

   localparam int unsigned DEPTH  = MAX_DEGREE + 1;
   localparam int unsigned ADDR_W = (DEPTH > 2) ? $clog2(DEPTH) : 1;
   localparam int unsigned SAT_DEGREE = (MAX_DEGREE > 255) ? 255 : MAX_DEGREE;

   logic [DEGREE_W-1:0]          degree_ff;
   logic [DEGREE_W-1:0]          degree_n;
   logic [CSR_SEL_W-1:0]         csr_sel;
   logic                         csr_wr;
   logic                         cfg_wr;

   logic                         wr_en;
   logic [ADDR_W-1:0]            wr_addr;
   logic [ADDR_W-1:0]            rd_addr_a;
   logic [ADDR_W-1:0]            rd_addr_b;
   logic [COEF_WIDTH-1:0]        rd_a;
   logic [COEF_WIDTH-1:0]        rd_b;
   mac_tag_type                  tag;
   logic signed [PROD_W-1:0]     acc;
   logic                         mac_done;
   logic                         load_out;
   logic                         out_free;
   logic [INDEX_W-1:0]           coef_index;
   logic                         last_coef;

   logic                         rsp_tvalid_ff;
   logic [PROD_W-1:0]            rsp_prod_ff;
   logic [INDEX_W-1:0]           rsp_index_ff;
   logic                         rsp_tlast_ff;

   // configuration port
   assign csr_pready = 1'b1;
   assign csr_sel    = csr_paddr[CSR_ADDR_W-1:2];
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign cfg_wr     = csr_wr && (csr_sel == REG_DEGREE);
   assign csr_prdata = (csr_sel == REG_DEGREE) ? CSR_DATA_W'(degree_ff) : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         degree_ff <= '0;
      end else if (cfg_wr) begin
         degree_ff <= csr_pwdata[DEGREE_W-1:0];
      end
   end

   assign degree_n = (32'(degree_ff) > SAT_DEGREE) ? DEGREE_W'(SAT_DEGREE) : degree_ff;

   pcm_ctrl #(
      .ADDR_W (ADDR_W)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .degree_n   (degree_n),
      .cfg_wr     (cfg_wr),
      .in_valid   (req_tvalid),
      .in_ready   (req_tready),
      .out_free   (out_free),
      .mac_done   (mac_done),
      .wr_en      (wr_en),
      .wr_addr    (wr_addr),
      .rd_addr_a  (rd_addr_a),
      .rd_addr_b  (rd_addr_b),
      .tag        (tag),
      .load_out   (load_out),
      .coef_index (coef_index),
      .last_coef  (last_coef)
   );

   pcm_coef_store #(
      .DEPTH  (DEPTH),
      .ADDR_W (ADDR_W),
      .DATA_W (COEF_WIDTH)
   ) u_store (
      .clock     (clock),
      .wr_en     (wr_en),
      .wr_addr   (wr_addr),
      .wr_a      (req_tdata[COEF_WIDTH-1:0]),
      .wr_b      (req_tdata[2*COEF_WIDTH-1:COEF_WIDTH]),
      .rd_addr_a (rd_addr_a),
      .rd_addr_b (rd_addr_b),
      .rd_a      (rd_a),
      .rd_b      (rd_b)
   );

   pcm_mac #(
      .COEF_WIDTH (COEF_WIDTH)
   ) u_mac (
      .clock (clock),
      .reset (reset),
      .tag   (tag),
      .op_a  (signed'(rd_a)),
      .op_b  (signed'(rd_b)),
      .acc   (acc),
      .done  (mac_done)
   );

   // output register
   assign out_free = !rsp_tvalid_ff || rsp_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_tvalid_ff <= 1'b0;
      end else if (load_out) begin
         rsp_tvalid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_tvalid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load_out) begin
         rsp_prod_ff  <= acc;
         rsp_index_ff <= coef_index;
         rsp_tlast_ff <= last_coef;
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tlast  = rsp_tlast_ff;
   assign rsp_tdata  = {(RSP_DATA_W - PROD_W - INDEX_W)'(0), rsp_index_ff, rsp_prod_ff};

   // checks
   a_load_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      load_out |-> (!rsp_tvalid_ff || rsp_tready))
      else $error("result loaded over a pending transaction");

   a_last_index: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid_ff && rsp_tlast_ff) |-> (rsp_index_ff == {degree_n, 1'b0}))
      else $error("last flag on a coefficient other than twice the degree");

   a_idle_pipe_empty: assert property (@(posedge clock) disable iff (reset)
      req_tready |-> (!tag.vld && !mac_done))
      else $error("accumulation still in flight while accepting");

   a_done_then_load: assert property (@(posedge clock) disable iff (reset)
      mac_done |=> !req_tready)
      else $error("sum finished but result not held for hand-over");

endmodule

`default_nettype wire
